// ===== design/tsss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsss_pkg
// Shared types and constants of the two stacks shared store unit.
// ----------------------------------------------------------------------------
package tsss_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 1024;
  localparam int unsigned CAP_W           = 11;
  localparam int unsigned CAP_RESET       = 1024;
  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned CMD_W           = 3;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned IN_W            = 40;
  localparam int unsigned OUT_W           = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FIRST  = 3'd0,
    CMD_PUSH_SECOND = 3'd1,
    CMD_POP_FIRST   = 3'd2,
    CMD_POP_SECOND  = 3'd3,
    CMD_PEEK_FIRST  = 3'd4,
    CMD_PEEK_SECOND = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  typedef struct packed {
    logic accept;
    logic load_read;
  } ctrl_t;

  typedef struct packed {
    logic needs_read;
  } stat_t;

endpackage

// ===== design/tsss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsss_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tsss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tsss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsss_ctrl
// Controller: input and output handshake, wait state for store reads.
// ----------------------------------------------------------------------------
module tsss_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  output logic            s_ready_o,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  input  tsss_pkg::stat_t stat_i,
  output tsss_pkg::ctrl_t ctrl_o
);

  tsss_pkg::state_e state_q, state_d;
  logic             out_vld_q, out_vld_d;
  logic             ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tsss_pkg::S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    out_vld_d        = out_vld_q && !m_ready_i;
    ready            = 1'b0;
    ctrl_o.accept    = 1'b0;
    ctrl_o.load_read = 1'b0;
    case (state_q)
      tsss_pkg::S_IDLE: begin
        ready         = !out_vld_q || m_ready_i;
        ctrl_o.accept = ready && s_valid_i;
        if (ctrl_o.accept) begin
          if (stat_i.needs_read) begin
            state_d = tsss_pkg::S_READ;
          end else begin
            out_vld_d = 1'b1;
          end
        end
      end
      tsss_pkg::S_READ: begin
        ctrl_o.load_read = 1'b1;
        out_vld_d        = 1'b1;
        state_d          = tsss_pkg::S_IDLE;
      end
      default: begin
        state_d = tsss_pkg::S_IDLE;
      end
    endcase
  end

  assign s_ready_o = ready;
  assign m_valid_o = out_vld_q;

endmodule

// ===== design/tsss_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsss_dp
// Datapath: capacity, stack counts, shared store and result register.
// ----------------------------------------------------------------------------
module tsss_dp #(
  parameter int unsigned STORE_DEPTH = tsss_pkg::STORE_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tsss_pkg::CAP_W-1:0]   cfg_wdata_i,
  input  logic [tsss_pkg::CMD_W-1:0]   cmd_i,
  input  logic [tsss_pkg::VALUE_W-1:0] push_value_i,
  input  tsss_pkg::ctrl_t              ctrl_i,
  output tsss_pkg::stat_t              stat_o,
  output logic [tsss_pkg::STATUS_W-1:0] status_o,
  output logic [tsss_pkg::VALUE_W-1:0] read_value_o,
  output logic                         first_empty_o,
  output logic                         second_empty_o
);

  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned AW   = $clog2(STORE_DEPTH);
  localparam int unsigned CapResetVal =
    (tsss_pkg::CAP_RESET > STORE_DEPTH) ? STORE_DEPTH : tsss_pkg::CAP_RESET;

  logic [CntW-1:0] cap_q, cap_clamped;
  logic [CntW-1:0] first_q, first_d, second_q, second_d;
  logic [CntW:0]   used;
  logic            has_room;
  logic [CntW-1:0] first_m1, second_top, second_push_top;
  tsss_pkg::cmd_e  cmd;
  logic [tsss_pkg::STATUS_W-1:0] status;
  logic [tsss_pkg::VALUE_W-1:0]  value_init;
  logic            needs_read;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [tsss_pkg::VALUE_W-1:0]  ram_rdata;

  logic [tsss_pkg::STATUS_W-1:0] res_status_q;
  logic [tsss_pkg::VALUE_W-1:0]  res_value_q;
  logic            res_fe_q, res_se_q;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cap_clamped = CntW'(1);
    end else if (32'(cfg_wdata_i) > 32'(STORE_DEPTH)) begin
      cap_clamped = CntW'(STORE_DEPTH);
    end else begin
      cap_clamped = CntW'(cfg_wdata_i);
    end
  end

  assign used            = {1'b0, first_q} + {1'b0, second_q};
  assign has_room        = used < {1'b0, cap_q};
  assign first_m1        = first_q - CntW'(1);
  assign second_top      = cap_q - second_q;
  assign second_push_top = cap_q - second_q - CntW'(1);
  assign cmd             = tsss_pkg::cmd_e'(cmd_i);

  always_comb begin
    first_d    = first_q;
    second_d   = second_q;
    status     = tsss_pkg::ST_OK;
    value_init = '0;
    needs_read = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = first_q[AW-1:0];
    ram_raddr  = first_m1[AW-1:0];
    case (cmd)
      tsss_pkg::CMD_PUSH_FIRST: begin
        if (has_room) begin
          ram_we  = 1'b1;
          first_d = first_q + CntW'(1);
        end else begin
          status = tsss_pkg::ST_OVERFLOW;
        end
      end
      tsss_pkg::CMD_PUSH_SECOND: begin
        ram_waddr = second_push_top[AW-1:0];
        if (has_room) begin
          ram_we   = 1'b1;
          second_d = second_q + CntW'(1);
        end else begin
          status = tsss_pkg::ST_OVERFLOW;
        end
      end
      tsss_pkg::CMD_POP_FIRST: begin
        if (first_q != '0) begin
          first_d = first_m1;
        end else begin
          status = tsss_pkg::ST_UNDERFLOW;
        end
      end
      tsss_pkg::CMD_POP_SECOND: begin
        if (second_q != '0) begin
          second_d = second_q - CntW'(1);
        end else begin
          status = tsss_pkg::ST_UNDERFLOW;
        end
      end
      tsss_pkg::CMD_PEEK_FIRST: begin
        if (first_q != '0) begin
          needs_read = 1'b1;
        end else begin
          status     = tsss_pkg::ST_EMPTY;
          value_init = '1;
        end
      end
      tsss_pkg::CMD_PEEK_SECOND: begin
        ram_raddr = second_top[AW-1:0];
        if (second_q != '0) begin
          needs_read = 1'b1;
        end else begin
          status     = tsss_pkg::ST_EMPTY;
          value_init = '1;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat_o.needs_read = needs_read;
  assign ram_re            = ctrl_i.accept && needs_read;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= CntW'(CapResetVal);
      first_q  <= '0;
      second_q <= '0;
    end else if (cfg_we_i) begin
      cap_q    <= cap_clamped;
      first_q  <= '0;
      second_q <= '0;
    end else if (ctrl_i.accept) begin
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      res_status_q <= status;
      res_value_q  <= value_init;
      res_fe_q     <= (first_d == '0);
      res_se_q     <= (second_d == '0);
    end else if (ctrl_i.load_read) begin
      res_value_q  <= ram_rdata;
    end
  end

  tsss_ram #(
    .WIDTH (tsss_pkg::VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.accept && ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (push_value_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o       = res_status_q;
  assign read_value_o   = res_value_q;
  assign first_empty_o  = res_fe_q;
  assign second_empty_o = res_se_q;

endmodule

// ===== design/two_stacks_shared_store_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stacks_shared_store_unit
// Two stacks in one shared store, growing toward each other.
// ----------------------------------------------------------------------------
// Push, pop, unused codes and a peek on an empty stack need no store read;
// a peek on a non-empty stack adds a wait state for the registered read
// port of the shared store. A result register separates the output, so a
// new beat is taken while the previous result is drained. Writing the
// capacity register empties both stacks; no clearing pass runs after reset.
module two_stacks_shared_store_unit #(
  parameter int unsigned STORE_DEPTH = tsss_pkg::STORE_DEPTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tsss_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [2:0] command, [34:3] push_value, [39:35] zero
  input  logic [tsss_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [1:0] status, [33:2] read_value, [34] first_empty, [35] second_empty,
  // [39:36] zero
  output logic [tsss_pkg::OUT_W-1:0] m_axis_tdata
);

  tsss_pkg::ctrl_t ctrl;
  tsss_pkg::stat_t stat;
  logic [tsss_pkg::STATUS_W-1:0] status;
  logic [tsss_pkg::VALUE_W-1:0]  read_value;
  logic                          first_empty, second_empty;

  tsss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  tsss_dp #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (s_axis_tdata[2:0]),
    .push_value_i   (s_axis_tdata[34:3]),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .status_o       (status),
    .read_value_o   (read_value),
    .first_empty_o  (first_empty),
    .second_empty_o (second_empty)
  );

  assign m_axis_tdata = {4'b0000, second_empty, first_empty, read_value, status};

endmodule
